>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the cycle after.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// Constants and helpers for the reciprocal square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package fisr_pkg;

  localparam logic [31:0] FISR_MAGIC        = 32'h5f3759df;
  localparam logic [31:0] FISR_HALF         = 32'h3f000000;
  localparam logic [31:0] FISR_THREE_HALVES = 32'h3fc00000;
  localparam logic [31:0] FISR_QNAN         = 32'h7fc00000;

  // leading zero count, 48 when all zero
  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fisr_fmul.sv
// ----------------------------------------------------------------------------
// fisr_fmul
// Single-precision multiply, round to nearest even, three register stages:
// mantissa product, leading zero count, shift and round.
// ----------------------------------------------------------------------------
`default_nettype none
module fisr_fmul
  import fisr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] p_o
);

  logic [7:0] ea, eb;
  logic       nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

  assign ea     = a_i[30:23];
  assign eb     = b_i[30:23];
  assign nan_a  = (ea == 8'hff) && (a_i[22:0] != '0);
  assign nan_b  = (eb == 8'hff) && (b_i[22:0] != '0);
  assign inf_a  = (ea == 8'hff) && (a_i[22:0] == '0);
  assign inf_b  = (eb == 8'hff) && (b_i[22:0] == '0);
  assign zero_a = (a_i[30:0] == '0);
  assign zero_b = (b_i[30:0] == '0);

  // stage 1
  logic               s1_sign_q, s1_nan_q, s1_inf_q;
  logic signed [9:0]  s1_exp_q;
  logic [47:0]        s1_prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= a_i[31] ^ b_i[31];
      s1_nan_q  <= nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
      s1_inf_q  <= inf_a | inf_b;
      s1_exp_q  <= $signed({2'b0, ((ea == '0) ? 8'd1 : ea)})
                 + $signed({2'b0, ((eb == '0) ? 8'd1 : eb)}) - 10'sd126;
      s1_prod_q <= {(ea != '0), a_i[22:0]} * {(eb != '0), b_i[22:0]};
    end
  end

  // stage 2
  logic [5:0]        lz;
  logic signed [9:0] e, k;
  logic              left_d;
  logic [5:0]        amt_d;

  assign lz = clz48(s1_prod_q);
  assign e  = s1_exp_q - $signed({4'b0, lz});
  assign k  = $signed({4'b0, lz}) + e - 10'sd1;

  always_comb begin
    left_d = 1'b1;
    amt_d  = lz;
    if (e < 10'sd1) begin
      if (k >= 10'sd0) begin
        amt_d = k[5:0];
      end else begin
        left_d = 1'b0;
        amt_d  = (-k > 10'sd63) ? 6'd63 : 6'(-k);
      end
    end
  end

  logic        s2_sign_q, s2_nan_q, s2_inf_q, s2_zero_q, s2_ovf_q, s2_left_q;
  logic [5:0]  s2_amt_q;
  logic [7:0]  s2_efield_q;
  logic [47:0] s2_prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q   <= s1_sign_q;
      s2_nan_q    <= s1_nan_q;
      s2_inf_q    <= s1_inf_q;
      s2_zero_q   <= (s1_prod_q == '0);
      s2_ovf_q    <= (e >= 10'sd255);
      s2_left_q   <= left_d;
      s2_amt_q    <= amt_d;
      s2_efield_q <= (e < 10'sd1) ? 8'd0 : e[7:0];
      s2_prod_q   <= s1_prod_q;
    end
  end

  // stage 3
  logic [47:0] sh;
  logic        sticky, rnd;
  logic [30:0] mag;
  logic [31:0] p_d;

  always_comb begin
    if (s2_left_q) begin
      sh     = s2_prod_q << s2_amt_q;
      sticky = 1'b0;
    end else begin
      sh     = s2_prod_q >> s2_amt_q;
      sticky = |(s2_prod_q & ~({48{1'b1}} << s2_amt_q));
    end
    rnd = sh[23] & ((|sh[22:0]) | sticky | sh[24]);
    mag = {s2_efield_q, sh[46:24]} + 31'(rnd);
    priority if (s2_nan_q)  p_d = FISR_QNAN;
    else if (s2_inf_q)      p_d = {s2_sign_q, 8'hff, 23'd0};
    else if (s2_zero_q)     p_d = {s2_sign_q, 31'd0};
    else if (s2_ovf_q)      p_d = {s2_sign_q, 8'hff, 23'd0};
    else                    p_d = {s2_sign_q, mag};
  end

  logic [31:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> hw/rtl/fisr_fadd.sv
// ----------------------------------------------------------------------------
// fisr_fadd
// Single-precision add, round to nearest even, four register stages:
// swap, align and add, leading zero count, normalize and round.
// ----------------------------------------------------------------------------
`default_nettype none
module fisr_fadd
  import fisr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] s_o
);

  logic [31:0] x, y;
  logic [7:0]  ex, ey, exe, eye, d;
  logic        nan_a, nan_b, inf_a, inf_b;

  assign x     = (a_i[30:0] >= b_i[30:0]) ? a_i : b_i;
  assign y     = (a_i[30:0] >= b_i[30:0]) ? b_i : a_i;
  assign ex    = x[30:23];
  assign ey    = y[30:23];
  assign exe   = (ex == '0) ? 8'd1 : ex;
  assign eye   = (ey == '0) ? 8'd1 : ey;
  assign d     = exe - eye;
  assign nan_a = (a_i[30:23] == 8'hff) && (a_i[22:0] != '0);
  assign nan_b = (b_i[30:23] == 8'hff) && (b_i[22:0] != '0);
  assign inf_a = (a_i[30:23] == 8'hff) && (a_i[22:0] == '0);
  assign inf_b = (b_i[30:23] == 8'hff) && (b_i[22:0] == '0);

  // stage 1
  logic        s1_sgn_q, s1_sub_q, s1_nan_q, s1_inf_q, s1_isgn_q;
  logic [7:0]  s1_ex_q;
  logic [4:0]  s1_d_q;
  logic [23:0] s1_mx_q, s1_my_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sgn_q  <= x[31];
      s1_sub_q  <= a_i[31] ^ b_i[31];
      s1_nan_q  <= nan_a | nan_b | (inf_a & inf_b & (a_i[31] ^ b_i[31]));
      s1_inf_q  <= inf_a | inf_b;
      s1_isgn_q <= inf_a ? a_i[31] : b_i[31];
      s1_ex_q   <= exe;
      s1_d_q    <= (d > 8'd31) ? 5'd31 : d[4:0];
      s1_mx_q   <= {(ex != '0), x[22:0]};
      s1_my_q   <= {(ey != '0), y[22:0]};
    end
  end

  // stage 2
  logic [26:0] yx, yal, xx;

  assign yx  = {s1_my_q, 3'b0};
  assign xx  = {s1_mx_q, 3'b0};
  assign yal = (yx >> s1_d_q) | 27'(|(yx & ~({27{1'b1}} << s1_d_q)));

  logic        s2_sgn_q, s2_sub_q, s2_nan_q, s2_inf_q, s2_isgn_q;
  logic [7:0]  s2_ex_q;
  logic [27:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sgn_q  <= s1_sgn_q;
      s2_sub_q  <= s1_sub_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_isgn_q <= s1_isgn_q;
      s2_ex_q   <= s1_ex_q;
      s2_sum_q  <= s1_sub_q ? ({1'b0, xx} - {1'b0, yal}) : ({1'b0, xx} + {1'b0, yal});
    end
  end

  // stage 3
  logic [5:0] lz;
  logic [7:0] lim;
  logic [4:0] amt_d;

  assign lz    = clz48({s2_sum_q[26:0], 21'h1fffff});
  assign lim   = s2_ex_q - 8'd1;
  assign amt_d = ({2'b0, lz} < lim) ? lz[4:0] : lim[4:0];

  logic        s3_sgn_q, s3_sub_q, s3_nan_q, s3_inf_q, s3_isgn_q, s3_zero_q;
  logic [4:0]  s3_amt_q;
  logic [8:0]  s3_e_q;
  logic [27:0] s3_sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sgn_q  <= s2_sgn_q;
      s3_sub_q  <= s2_sub_q;
      s3_nan_q  <= s2_nan_q;
      s3_inf_q  <= s2_inf_q;
      s3_isgn_q <= s2_isgn_q;
      s3_zero_q <= (s2_sum_q == '0);
      s3_amt_q  <= amt_d;
      s3_e_q    <= s2_sum_q[27] ? ({1'b0, s2_ex_q} + 9'd1)
                                : ({1'b0, s2_ex_q} - {4'b0, amt_d});
      s3_sum_q  <= s2_sum_q;
    end
  end

  // stage 4
  logic [26:0] n;
  logic [7:0]  efield;
  logic        rnd;
  logic [30:0] mag;
  logic [31:0] s_d;

  always_comb begin
    n      = s3_sum_q[27] ? {s3_sum_q[27:2], s3_sum_q[1] | s3_sum_q[0]}
                          : (s3_sum_q[26:0] << s3_amt_q);
    efield = n[26] ? s3_e_q[7:0] : 8'd0;
    rnd    = n[2] & (n[1] | n[0] | n[3]);
    mag    = {efield, n[25:3]} + 31'(rnd);
    priority if (s3_nan_q)      s_d = FISR_QNAN;
    else if (s3_inf_q)          s_d = {s3_isgn_q, 8'hff, 23'd0};
    else if (s3_zero_q)         s_d = {s3_sgn_q & ~s3_sub_q, 31'd0};
    else if (s3_e_q >= 9'd255)  s_d = {s3_sgn_q, 8'hff, 23'd0};
    else                        s_d = {s3_sgn_q, mag};
  end

  logic [31:0] s_q;

  always_ff @(posedge clk_i) begin
    if (en_i) s_q <= s_d;
  end

  assign s_o = s_q;

endmodule
`default_nettype wire

>>> hw/rtl/fast_inverse_square_root.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Reciprocal square root estimate with the magic-constant trick and one
// Newton step in single precision.
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata, low bit up)
// s_axis   in   number_bits[31:0]
// m_axis   out  result_bits[31:0]
//
// One beat per cycle in, one per cycle out, except while the pipeline holds.
// The pipeline is the chain half, half*y, *y, 1.5-t, y*t.
// Reset clears the valid line only.
// The whole pipeline holds while a result waits and m_axis_tready_i is low.
// ----------------------------------------------------------------------------
`default_nettype none
module fast_inverse_square_root
  import fisr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // number_bits[31:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o    // result_bits[31:0]
);

  logic        en;
  logic [15:0] vld_q;
  logic [31:0] y_q [13];
  logic [31:0] half, t1, t2, t3, res;

  assign en              = ~vld_q[15] | m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[14:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q[0] <= FISR_MAGIC - {s_axis_tdata_i[31], s_axis_tdata_i[31:1]};
      for (int i = 1; i < 13; i++) y_q[i] <= y_q[i-1];
    end
  end

  fisr_fmul u_half (.clk_i, .en_i(en), .a_i(s_axis_tdata_i), .b_i(FISR_HALF), .p_o(half));
  fisr_fmul u_hy   (.clk_i, .en_i(en), .a_i(half), .b_i(y_q[2]), .p_o(t1));
  fisr_fmul u_hyy  (.clk_i, .en_i(en), .a_i(t1), .b_i(y_q[5]), .p_o(t2));
  fisr_fadd u_sub  (.clk_i, .en_i(en), .a_i(FISR_THREE_HALVES),
                    .b_i({~t2[31], t2[30:0]}), .s_o(t3));
  fisr_fmul u_newt (.clk_i, .en_i(en), .a_i(y_q[12]), .b_i(t3), .p_o(res));

  assign m_axis_tvalid_o = vld_q[15];
  assign m_axis_tdata_o  = res;

endmodule
`default_nettype wire

>>> hw/rtl/fisr_checker.sv
// ----------------------------------------------------------------------------
// fisr_checker
// Port-level checks for the reciprocal square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fisr_checker
  import fisr_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [31:0] s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o
);

  logic nan_out;
  logic out_wait;
  logic in_beat;

  assign nan_out  = (m_axis_tdata_o[30:23] == 8'hff) && (m_axis_tdata_o[22:0] != '0);
  assign out_wait = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid_o)
  `ASSERT_NEXT(a_data_hold, clk_i, rst_ni, out_wait, $stable(m_axis_tdata_o))
  `ASSERT_ALWAYS(a_ready, clk_i, rst_ni, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
  `ASSERT_ALWAYS(a_qnan, clk_i, rst_ni, !(m_axis_tvalid_o && nan_out) || (m_axis_tdata_o == FISR_QNAN))
  `ASSERT_ALWAYS(a_in_known, clk_i, rst_ni, !in_beat || !$isunknown(s_axis_tdata_i))

endmodule

bind fast_inverse_square_root fisr_checker u_fisr_checker (.*);
`default_nettype wire
